FILE: design/cascaded_biquad_bandpass_defines.svh
// Assertion helpers for the filter modules, included by the section module.
`ifndef CASCADED_BIQUAD_BANDPASS_DEFINES_SVH
`define CASCADED_BIQUAD_BANDPASS_DEFINES_SVH

// General form: named concurrent check on a given clock and active-low reset.
`define CBB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Shorthand for the usual clock and reset of this block.
`define CBB_CHECK(lbl, prop, msg) \
  `CBB_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/cbb_pkg.sv
package cbb_pkg;

  localparam int STAGES      = 6;
  localparam int MAX_STAGES  = 6;
  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_BITS  = 48;
  localparam int COEF_BITS   = 32;
  localparam int COEF_FRAC   = 30;
  localparam int GAIN_BITS   = 48;
  localparam int GAIN_FRAC   = 46;
  localparam int CFG_BITS    = 64;
  localparam int CFG_IDX_BITS = $clog2(MAX_STAGES + 1);

  // Guard bits below the sample range inside the signal word.
  localparam int SIG_SHIFT = (DELAY_BITS - SAMPLE_BITS - 8 > 0) ?
                             (DELAY_BITS - SAMPLE_BITS - 8) : 0;
  localparam int SIG_HALF  = DELAY_BITS / 2;
  localparam int GAIN_HALF = GAIN_BITS / 2;

  typedef logic signed [DELAY_BITS-1:0]  sig_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Forward half of a link between neighbouring cells.
  typedef struct packed {
    logic valid;
    sig_t word;
  } link_t;

  // Register write as seen by one cell.
  typedef struct packed {
    logic                we;
    logic [CFG_BITS-1:0] data;
  } cfg_wr_t;

  localparam sig_t  SIG_MAX  = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam sig_t  SIG_MIN  = {1'b1, {(DELAY_BITS-1){1'b0}}};
  localparam gain_t GAIN_ONE = gain_t'(64'd1 << GAIN_FRAC);

  function automatic sig_t sat_add(sig_t a, sig_t b);
    logic [DELAY_BITS:0] s;
    s = {a[DELAY_BITS-1], a} + {b[DELAY_BITS-1], b};
    if (s[DELAY_BITS] != s[DELAY_BITS-1]) begin
      return s[DELAY_BITS] ? SIG_MIN : SIG_MAX;
    end
    return s[DELAY_BITS-1:0];
  endfunction

  function automatic sig_t sat_sub(sig_t a, sig_t b);
    logic [DELAY_BITS:0] s;
    s = {a[DELAY_BITS-1], a} - {b[DELAY_BITS-1], b};
    if (s[DELAY_BITS] != s[DELAY_BITS-1]) begin
      return s[DELAY_BITS] ? SIG_MIN : SIG_MAX;
    end
    return s[DELAY_BITS-1:0];
  endfunction

endpackage

FILE: design/cascaded_biquad_bandpass.sv
// Band-pass filter built from a row of direct-form-II biquad sections, with the
// normalising gain applied between the first and second section. Each section
// owns its delay words and feedback coefficients and its own narrow multiplier;
// it steps through the four partial products of its two feedback terms followed
// by the saturating sums. The gain stage likewise works through four partial products.
// Sections run on successive samples at the same time, so a new sample word is
// accepted only once the first section has handed the previous one on.
// Register writes are always taken and act at once, so they belong in quiet
// periods. Internal sums and products saturate silently; only the final
// rounding to the sample width raises the clip flag.
module cascaded_biquad_bandpass (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  cbb_pkg::sample_t                    sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output cbb_pkg::sample_t                    sample_out_o,
  output logic                                clipped_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbb_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [cbb_pkg::CFG_BITS-1:0]        cfg_data_i
);
  import cbb_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN = CFG_IDX_BITS'(MAX_STAGES);
  localparam int CV_W = DELAY_BITS - SIG_SHIFT + 1;
  localparam int RB   = (SIG_SHIFT > 0) ? SIG_SHIFT - 1 : 0;

  link_t   in_link, scale_out, tail;
  logic    scale_in_ready, scale_out_ready, tail_ready;
  cfg_wr_t scale_cfg;

  link_t   sec_in        [STAGES];
  link_t   sec_out       [STAGES];
  logic    sec_in_ready  [STAGES];
  logic    sec_out_ready [STAGES];
  cfg_wr_t sec_cfg       [STAGES];

  logic signed [CV_W-1:0] conv_r;
  sample_t conv_sample;
  logic    conv_clip;
  sample_t sample_q;
  logic    clip_q;
  logic    out_valid_q;

  assign in_link.valid = in_valid_i;
  assign in_link.word  = sig_t'(sample_in_i) <<< SIG_SHIFT;
  assign in_ready_o    = sec_in_ready[0];
  assign cfg_ready_o   = 1'b1;

  assign scale_cfg.we   = cfg_valid_i && (cfg_index_i == REG_GAIN);
  assign scale_cfg.data = cfg_data_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_sec
    assign sec_cfg[i].we   = cfg_valid_i && (cfg_index_i == CFG_IDX_BITS'(i));
    assign sec_cfg[i].data = cfg_data_i;

    if (i == 0) begin : g_head
      assign sec_in[i] = in_link;
    end else if (i == 1) begin : g_after_gain
      assign sec_in[i]       = scale_out;
      assign scale_out_ready = sec_in_ready[i];
    end else begin : g_mid
      assign sec_in[i]          = sec_out[i-1];
      assign sec_out_ready[i-1] = sec_in_ready[i];
    end

    cbb_section u_sec (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .odd_i       (1'(i % 2)),
      .cfg_i       (sec_cfg[i]),
      .in_i        (sec_in[i]),
      .in_ready_o  (sec_in_ready[i]),
      .out_o       (sec_out[i]),
      .out_ready_i (sec_out_ready[i])
    );
  end

  assign sec_out_ready[0] = scale_in_ready;

  cbb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_cfg),
    .in_i        (sec_out[0]),
    .in_ready_o  (scale_in_ready),
    .out_o       (scale_out),
    .out_ready_i (scale_out_ready)
  );

  assign tail                     = sec_out[STAGES-1];
  assign tail_ready               = !out_valid_q || out_ready_i;
  assign sec_out_ready[STAGES-1]  = tail_ready;

  // Drop the guard bits rounding half up, then clamp to the sample width.
  always_comb begin
    conv_r = CV_W'(tail.word >>> SIG_SHIFT)
           + {{(CV_W-1){1'b0}}, (SIG_SHIFT > 0) ? tail.word[RB] : 1'b0};
    conv_clip   = (|conv_r[CV_W-1:SAMPLE_BITS-1]) && !(&conv_r[CV_W-1:SAMPLE_BITS-1]);
    conv_sample = conv_r[SAMPLE_BITS-1:0];
    if (conv_clip) begin
      conv_sample = conv_r[CV_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tail.valid && tail_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid && tail_ready) begin
      sample_q <= conv_sample;
      clip_q   <= conv_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;
  assign clipped_o    = clip_q;

endmodule

FILE: design/cbb_section.sv
`include "cascaded_biquad_bandpass_defines.svh"

module cbb_section (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             odd_i,
  input  cbb_pkg::cfg_wr_t cfg_i,
  input  cbb_pkg::link_t   in_i,
  output logic             in_ready_o,
  output cbb_pkg::link_t   out_o,
  input  logic             out_ready_i
);
  import cbb_pkg::*;

  localparam int OP_W   = SIG_HALF + 1;
  localparam int PROD_W = OP_W + COEF_BITS;
  localparam int ACC_W  = DELAY_BITS + COEF_BITS + 1;
  localparam int RND_W  = ACC_W - COEF_FRAC;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_M1L  = 12'h002,
    S_M1H  = 12'h004,
    S_A1   = 12'h008,
    S_R1   = 12'h010,
    S_M2H  = 12'h020,
    S_A2   = 12'h040,
    S_R2   = 12'h080,
    S_W2   = 12'h100,
    S_Y1   = 12'h200,
    S_Y2   = 12'h400,
    S_Y3   = 12'h800
  } sec_state_e;

  sec_state_e state_q, state_d;
  sig_t  x_q, w_q, y_q, t_q, out_q;
  sig_t  d1_q, d2_q;
  coef_t a1_q, a2_q;
  logic  out_valid_q;
  logic  fire;

  logic signed [OP_W-1:0]      mul_a;
  coef_t                       mul_b;
  logic signed [PROD_W-1:0]    prod_w, prod_q;
  logic signed [ACC_W-1:0]     acc_q;

  // Round half away from zero, then saturate to the signal word.
  function automatic sig_t fb_round(logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] r;
    logic signed [RND_W-1:0] q;
    r = p + RND_HALF - ACC_W'(p[ACC_W-1]);
    q = RND_W'(r >>> COEF_FRAC);
    if ((|q[RND_W-1:DELAY_BITS-1]) && !(&q[RND_W-1:DELAY_BITS-1])) begin
      return q[RND_W-1] ? SIG_MIN : SIG_MAX;
    end
    return q[DELAY_BITS-1:0];
  endfunction

  assign fire = (state_q == S_Y3) && (!out_valid_q || out_ready_i);

  // Each delay word is split in halves so one narrow multiplier serves both products.
  always_comb begin
    mul_a = '0;
    mul_b = a1_q;
    case (state_q)
      S_M1L: mul_a = OP_W'({1'b0, d1_q[SIG_HALF-1:0]});
      S_M1H: mul_a = OP_W'(signed'(d1_q[DELAY_BITS-1:SIG_HALF]));
      S_R1: begin
        mul_a = OP_W'({1'b0, d2_q[SIG_HALF-1:0]});
        mul_b = a2_q;
      end
      S_M2H: begin
        mul_a = OP_W'(signed'(d2_q[DELAY_BITS-1:SIG_HALF]));
        mul_b = a2_q;
      end
      default: ;
    endcase
  end

  assign prod_w = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_M1L;
      S_M1L:  state_d = S_M1H;
      S_M1H:  state_d = S_A1;
      S_A1:   state_d = S_R1;
      S_R1:   state_d = S_M2H;
      S_M2H:  state_d = S_A2;
      S_A2:   state_d = S_R2;
      S_R2:   state_d = S_W2;
      S_W2:   state_d = S_Y1;
      S_Y1:   state_d = S_Y2;
      S_Y2:   state_d = S_Y3;
      S_Y3:   if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        d2_q <= d1_q;
        d1_q <= w_q;
      end
      if (cfg_i.we) begin
        a1_q <= cfg_i.data[CFG_BITS-1:COEF_BITS];
        a2_q <= cfg_i.data[COEF_BITS-1:0];
      end
    end
  end

  // The feedback products are accumulated negated, so the rounding sees -a*d directly.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_w;
    case (state_q)
      S_IDLE: if (in_i.valid) x_q <= in_i.word;
      S_M1H:  acc_q <= -ACC_W'(prod_q);
      S_A1:   acc_q <= acc_q - (ACC_W'(prod_q) <<< SIG_HALF);
      S_R1:   t_q <= fb_round(acc_q);
      S_M2H: begin
        w_q   <= sat_add(x_q, t_q);
        acc_q <= -ACC_W'(prod_q);
      end
      S_A2:   acc_q <= acc_q - (ACC_W'(prod_q) <<< SIG_HALF);
      S_R2:   t_q <= fb_round(acc_q);
      S_W2:   w_q <= sat_add(w_q, t_q);
      S_Y1:   y_q <= odd_i ? sat_sub(w_q, d1_q) : sat_add(w_q, d1_q);
      S_Y2:   y_q <= odd_i ? sat_sub(y_q, d1_q) : sat_add(y_q, d1_q);
      S_Y3:   if (fire) out_q <= sat_add(y_q, d2_q);
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_q;

  `CBB_CHECK(a_delay_hold, !fire |=> $stable(d1_q) && $stable(d2_q), "delay words moved outside the final step")
  `CBB_CHECK(a_finish_idle, fire |=> (state_q == S_IDLE) && out_valid_q, "section did not hand its word on")
  `CBB_CHECK(a_one_word, (in_i.valid && in_ready_o) |=> !in_ready_o, "section took a second word while busy")

endmodule

FILE: design/cbb_scale.sv
module cbb_scale (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbb_pkg::cfg_wr_t cfg_i,
  input  cbb_pkg::link_t   in_i,
  output logic             in_ready_o,
  output cbb_pkg::link_t   out_o,
  input  logic             out_ready_i
);
  import cbb_pkg::*;

  localparam int YOP_W  = SIG_HALF + 1;
  localparam int GOP_W  = GAIN_HALF + 1;
  localparam int PROD_W = YOP_W + GOP_W;
  localparam int ACC_W  = DELAY_BITS + GAIN_BITS + 1;
  localparam int RND_W  = ACC_W - GAIN_FRAC;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (GAIN_FRAC - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'h01,
    S_LL   = 7'h02,
    S_LH   = 7'h04,
    S_HL   = 7'h08,
    S_HH   = 7'h10,
    S_SUM  = 7'h20,
    S_RND  = 7'h40
  } scl_state_e;

  scl_state_e state_q, state_d;
  gain_t gain_q;
  sig_t  y_q, out_q;
  logic  out_valid_q;
  logic  fire;

  logic signed [YOP_W-1:0]  ylo, yhi;
  logic signed [GOP_W-1:0]  glo, ghi;
  logic signed [YOP_W-1:0]  mul_a;
  logic signed [GOP_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_w, prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  function automatic sig_t gain_round(logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] r;
    logic signed [RND_W-1:0] q;
    r = p + RND_HALF - ACC_W'(p[ACC_W-1]);
    q = RND_W'(r >>> GAIN_FRAC);
    if ((|q[RND_W-1:DELAY_BITS-1]) && !(&q[RND_W-1:DELAY_BITS-1])) begin
      return q[RND_W-1] ? SIG_MIN : SIG_MAX;
    end
    return q[DELAY_BITS-1:0];
  endfunction

  assign ylo = YOP_W'({1'b0, y_q[SIG_HALF-1:0]});
  assign yhi = YOP_W'(signed'(y_q[DELAY_BITS-1:SIG_HALF]));
  assign glo = GOP_W'({1'b0, gain_q[GAIN_HALF-1:0]});
  assign ghi = GOP_W'(signed'(gain_q[GAIN_BITS-1:GAIN_HALF]));

  assign fire = (state_q == S_RND) && (!out_valid_q || out_ready_i);

  always_comb begin
    mul_a = ylo;
    mul_b = glo;
    case (state_q)
      S_LH: mul_b = ghi;
      S_HL: mul_a = yhi;
      S_HH: begin
        mul_a = yhi;
        mul_b = ghi;
      end
      default: ;
    endcase
  end

  assign prod_w = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_LL;
      S_LL:   state_d = S_LH;
      S_LH:   state_d = S_HL;
      S_HL:   state_d = S_HH;
      S_HH:   state_d = S_SUM;
      S_SUM:  state_d = S_RND;
      S_RND:  if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      gain_q      <= GAIN_ONE;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.we) begin
        gain_q <= cfg_i.data[GAIN_BITS-1:0];
      end
    end
  end

  // Four partial products, each shifted to its weight as it is added in.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_w;
    case (state_q)
      S_IDLE: if (in_i.valid) y_q <= in_i.word;
      S_LH:   acc_q <= ACC_W'(prod_q);
      S_HL:   acc_q <= acc_q + (ACC_W'(prod_q) <<< GAIN_HALF);
      S_HH:   acc_q <= acc_q + (ACC_W'(prod_q) <<< SIG_HALF);
      S_SUM:  acc_q <= acc_q + (ACC_W'(prod_q) <<< (SIG_HALF + GAIN_HALF));
      S_RND:  if (fire) out_q <= gain_round(acc_q);
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_q;

endmodule

FILE: bench/tb_cascaded_biquad_bandpass.sv
`timescale 1ns / 100ps

module tb_cascaded_biquad_bandpass;
  import cbb_pkg::*;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  typedef struct {
    sample_t sample;
    logic    clipped;
  } filtered_t;

  localparam cfg_idx_t REG_STAGE0 = '0;
  localparam cfg_idx_t REG_GAIN   = cfg_idx_t'(MAX_STAGES);
  localparam cfg_idx_t REG_SPARE  = cfg_idx_t'(MAX_STAGES + 1);

  localparam sample_t SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint  SAMPLE_MAX    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint  SAMPLE_MIN    = -SAMPLE_MAX - 1;
  localparam int      IDLE_LIMIT    = 5000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  sample_t               sample_in_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  sample_t               sample_out_o;
  logic                  clipped_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_t              cfg_index_i = '0;
  logic [CFG_BITS-1:0]   cfg_data_i  = '0;

  // Shadow copy of the filter's registers and delay words.
  coef_t fb_a1 [MAX_STAGES] = '{default: '0};
  coef_t fb_a2 [MAX_STAGES] = '{default: '0};
  gain_t gain_q46           = GAIN_ONE;
  sig_t  delay_d1 [MAX_STAGES] = '{default: '0};
  sig_t  delay_d2 [MAX_STAGES] = '{default: '0};

  logic [CFG_BITS-1:0] next_feedback [MAX_STAGES];
  filtered_t           filtered_q [$];
  filtered_t           due;
  int                  error_count  = 0;
  int                  words_seen   = 0;
  int                  burst_left   = 0;
  int                  quiet_cycles = 0;
  int unsigned         stall_mode   = 0;
  int unsigned         stall_run    = 0;
  logic [7:0]          stall_mask   = 8'hff;

  cascaded_biquad_bandpass dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic sig_t clamp_sig(input logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = SIG_MAX;
    lo = SIG_MIN;
    if (v > hi) return SIG_MAX;
    if (v < lo) return SIG_MIN;
    return v[DELAY_BITS-1:0];
  endfunction

  function automatic sig_t sum_sat(input sig_t a, input sig_t b);
    logic signed [127:0] s;
    s = a;
    s = s + b;
    return clamp_sig(s);
  endfunction

  function automatic sig_t diff_sat(input sig_t a, input sig_t b);
    logic signed [127:0] s;
    s = a;
    s = s - b;
    return clamp_sig(s);
  endfunction

  // Exact product, scaled down by 2^frac with rounding half away from zero.
  function automatic sig_t scaled_product(input sig_t v, input logic signed [63:0] c,
                                          input int frac);
    logic signed [127:0] sv, sc;
    logic [127:0] mv, mc, q, lim;
    logic neg;
    sv = v;
    sc = c;
    neg = (sv < 0) != (sc < 0);
    mv = (sv < 0) ? -sv : sv;
    mc = (sc < 0) ? -sc : sc;
    q = (mv * mc + (128'd1 << (frac - 1))) >> frac;
    lim = neg ? (128'd1 << (DELAY_BITS - 1)) : (128'd1 << (DELAY_BITS - 1)) - 1;
    if (q > lim) q = lim;
    return neg ? sig_t'(-q) : sig_t'(q);
  endfunction

  // Runs one sample through the shadow filter and advances its delay words.
  function automatic filtered_t filter_sample(input sample_t s);
    sig_t x, w, y, d1, d2;
    logic signed [63:0] na1, na2, gl;
    longint acc, f;
    filtered_t r;
    x = s;
    x = x <<< SIG_SHIFT;
    for (int i = 0; i < STAGES; i++) begin
      d1 = delay_d1[i];
      d2 = delay_d2[i];
      na1 = fb_a1[i];
      na1 = -na1;
      na2 = fb_a2[i];
      na2 = -na2;
      w = sum_sat(x, scaled_product(d1, na1, COEF_FRAC));
      w = sum_sat(w, scaled_product(d2, na2, COEF_FRAC));
      if (i % 2 == 0) begin
        y = sum_sat(sum_sat(w, d1), d1);
      end else begin
        y = diff_sat(diff_sat(w, d1), d1);
      end
      y = sum_sat(y, d2);
      delay_d2[i] = d1;
      delay_d1[i] = w;
      if (i == 0) begin
        gl = gain_q46;
        y = scaled_product(y, gl, GAIN_FRAC);
      end
      x = y;
    end
    acc = x;
    f = (acc >>> SIG_SHIFT) + longint'(acc[SIG_SHIFT-1]);
    r.clipped = 1'b0;
    if (f > SAMPLE_MAX) begin
      f = SAMPLE_MAX;
      r.clipped = 1'b1;
    end
    if (f < SAMPLE_MIN) begin
      f = SAMPLE_MIN;
      r.clipped = 1'b1;
    end
    r.sample = f[SAMPLE_BITS-1:0];
    return r;
  endfunction

  // Poles drawn from inside the stability triangle, so the filter rings without running away.
  function automatic logic [CFG_BITS-1:0] stable_feedback();
    longint a1, a2, lim;
    a2 = $urandom_range(322122547, 1041529569);
    lim = ((longint'(1) << COEF_FRAC) + a2) * 15 / 16;
    a1 = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    return {a1[31:0], a2[31:0]};
  endfunction

  function automatic gain_t random_gain();
    gain_t g;
    g = GAIN_ONE >>> $urandom_range(0, 9);
    if ($urandom_range(0, 1)) g = -g;
    return g;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s = sample_t'($urandom);
    case ($urandom_range(0, 7))
      0: s = $urandom_range(0, 1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
      1, 2, 3: s = s >>> $urandom_range(1, 14);
      default: ;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic send_sample(input sample_t s);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    sample_in_i <= s;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    filtered_q.push_back(filter_sample(s));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] data, input bit last);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < REG_GAIN) begin
      fb_a1[idx] = data[63:32];
      fb_a2[idx] = data[31:0];
    end else if (idx == REG_GAIN) begin
      gain_q46 = data[GAIN_BITS-1:0];
    end
    if (last) cfg_valid_i <= 1'b0;
  endtask

  // Writes every register; the spare index beyond the list must leave the filter alone.
  task automatic program_filter(input gain_t g, input bit stray);
    for (int i = 0; i < MAX_STAGES; i++) begin
      write_reg(cfg_idx_t'(REG_STAGE0 + i), next_feedback[i], 1'b0);
    end
    if (stray) write_reg(REG_SPARE, {$urandom, $urandom}, 1'b0);
    write_reg(REG_GAIN, {16'($urandom), g}, 1'b1);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (filtered_q.size() != 0);
  endtask

  // With reset coefficients the cascade is a pure FIR; full-scale steps drive it into clipping.
  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(SAMPLE_TOP);
    send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_BOTTOM);
    send_sample('0);
    send_sample(-1);
    send_sample(1);
    send_sample(SAMPLE_TOP);
    send_sample(SAMPLE_TOP);
    send_sample(SAMPLE_BOTTOM);
    send_sample(SAMPLE_BOTTOM);
    send_sample(SAMPLE_TOP);
    send_sample('0);
    drain_results();
  endtask

  // Extreme feedback and gain values saturate products and sums inside the sections.
  task automatic test_coefficient_extremes();
    next_feedback = '{default: 64'h8000_0000_7fff_ffff};
    program_filter({1'b0, {(GAIN_BITS-1){1'b1}}}, 1'b0);
    send_sample(SAMPLE_TOP);
    send_sample(SAMPLE_BOTTOM);
    send_sample('0);
    send_sample(1);
    drain_results();
    next_feedback = '{default: '1};
    program_filter({1'b1, {(GAIN_BITS-1){1'b0}}}, 1'b1);
    send_sample(SAMPLE_TOP);
    send_sample(-1);
    send_sample('0);
    drain_results();
    next_feedback = '{default: 64'h7fff_ffff_8000_0000};
    program_filter('0, 1'b1);
    send_sample(SAMPLE_TOP);
    send_sample(SAMPLE_BOTTOM);
    drain_results();
  endtask

  task automatic test_stable_filters();
    for (int phase = 0; phase < 6; phase++) begin
      foreach (next_feedback[i]) next_feedback[i] = stable_feedback();
      program_filter(random_gain(), phase[0]);
      repeat (150) send_sample(random_sample());
      drain_results();
    end
  endtask

  task automatic test_random_registers();
    for (int phase = 0; phase < 3; phase++) begin
      foreach (next_feedback[i]) next_feedback[i] = {$urandom, $urandom};
      program_filter(gain_t'({$urandom, $urandom}), 1'b1);
      repeat (130) send_sample(random_sample());
      drain_results();
    end
  endtask

  // Receiver back-pressure: runs of always-ready, random, sparse and fixed-mask stalls.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(50, 300);
      stall_mask = 8'($urandom_range(1, 255));
    end
    stall_run--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= stall_mask[stall_run % 8];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("output word %0d arrived with nothing outstanding",
                                  words_seen));
      end else begin
        due = filtered_q.pop_front();
        if (sample_out_o !== due.sample) begin
          report_mismatch($sformatf("word %0d sample_out %0d, predicted %0d",
                                    words_seen, sample_out_o, due.sample));
        end
        if (clipped_o !== due.clipped) begin
          report_mismatch($sformatf("word %0d clipped %b, predicted %b",
                                    words_seen, clipped_o, due.clipped));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles with no handshake", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_coefficient_extremes();
    test_stable_filters();
    test_random_registers();
    drain_results();
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && filtered_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: cascaded_biquad_bandpass.f
+incdir+design
design/cbb_pkg.sv
design/cbb_section.sv
design/cbb_scale.sv
design/cascaded_biquad_bandpass.sv
bench/tb_cascaded_biquad_bandpass.sv
